[hdl/mexp_pkg.sv]
`default_nettype none
package mexp_pkg;

  // Fixed field widths of the request and result.
  localparam int unsigned BASE_W = 30;
  localparam int unsigned EXPONENT_W = 32;
  localparam int unsigned POWER_W = 30;
  localparam int unsigned MODULUS_W = 30;

  // Defaults for the top-level parameters.
  localparam int unsigned EXP_BITS_DEF = 32;
  localparam int unsigned MOD_BITS_DEF = 30;

  // Modulus after reset: 1e9+7.
  localparam logic [31:0] MODULUS_RESET = 32'd1000000007;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_REDUCE = 6'b000010,
    S_CHECK  = 6'b000100,
    S_MUL    = 6'b001000,
    S_COMMIT = 6'b010000,
    S_FIN    = 6'b100000
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic reduce_step;
    logic mul_start;
    logic mul_step;
    logic commit;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic m_small;
    logic e_zero;
  } dp_status_t;

endpackage
`default_nettype wire

[hdl/modular_exponentiation.sv]
// Modular exponentiation: power = base ** exponent mod modulus.
// A request is taken at a rising edge where start is high and busy is low;
// base_i and exponent_i are sampled at that edge. busy stays high until the
// result has been delivered. The result appears on power_o with done_o high
// for exactly one cycle; the receiver cannot stall, so it must take it then.
// The modulus register is written with modulus_we_i/modulus_i and resets
// to 1000000007; the user must write it only while idle, which the block
// itself does not enforce. A modulus below 2 gives a power of 0 and skips
// all arithmetic, so done_o then rises in the cycle after the request.
// Otherwise the bit-serial modular multipliers set the pace: the base is
// first reduced one bit per cycle over its 30 bits; then each exponent bit,
// up to the highest set one and at most EXP_BITS of them, costs MOD_BITS
// doubling-add-reduce steps, with the multiply and the square running side
// by side in two lanes.
// busy drops the cycle after done_o, so a new request can follow then.
// Reset is asynchronous and active low; it returns the block to idle and
// restores the modulus.
`default_nettype none
module modular_exponentiation
  import mexp_pkg::*;
#(
  parameter int unsigned EXP_BITS = EXP_BITS_DEF,
  parameter int unsigned MOD_BITS = MOD_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [BASE_W-1:0]     base_i,
  input  logic [EXPONENT_W-1:0] exponent_i,
  output logic                  done_o,
  output logic [POWER_W-1:0]    power_o,
  input  logic                  modulus_we_i,
  input  logic [MODULUS_W-1:0]  modulus_i
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // The controller sequences base reduction, then per exponent bit one
  // check, MOD_BITS multiply steps and a commit of the new accumulator.
  mexp_ctrl #(
    .MOD_BITS (MOD_BITS)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy),
    .done_o   (done_o)
  );

  // The datapath holds the modulus, the exponent shifter, the accumulator,
  // the running base and the two modular multiply lanes.
  mexp_dp #(
    .EXP_BITS (EXP_BITS),
    .MOD_BITS (MOD_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .modulus_we_i (modulus_we_i),
    .modulus_i    (modulus_i),
    .base_i       (base_i),
    .exponent_i   (exponent_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .power_o      (power_o)
  );

`ifndef SYNTHESIS
  // An accepted request always makes the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted request did not raise busy");

  // The result strobe is a single-cycle pulse and is followed by idle.
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o && !busy)
    else $error("done strobe longer than one cycle or block not idle after it");

  // A result is only delivered while a request is in flight.
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy)
    else $error("result delivered while idle");
`endif

endmodule
`default_nettype wire

[hdl/mexp_lane.sv]
`default_nettype none
// One radix-2 step of an interleaved modular multiply: (2*r + add) mod m,
// with r and add both below m, so the sum stays below 3*m.
module mexp_lane #(
  parameter int unsigned W = 30
) (
  input  logic [W-1:0] r_i,
  input  logic [W-1:0] add_i,
  input  logic [W-1:0] m_i,
  output logic [W-1:0] r_o
);

  logic [W+1:0] sum;
  logic [W+1:0] m1;
  logic [W+1:0] m2;

  always_comb begin
    sum = {1'b0, r_i, 1'b0} + {2'b00, add_i};
    m1  = {2'b00, m_i};
    m2  = {1'b0, m_i, 1'b0};
    if (sum >= m2) begin
      r_o = W'(sum - m2);
    end else if (sum >= m1) begin
      r_o = W'(sum - m1);
    end else begin
      r_o = W'(sum);
    end
  end

endmodule
`default_nettype wire

[hdl/mexp_dp.sv]
`default_nettype none
module mexp_dp
  import mexp_pkg::*;
#(
  parameter int unsigned EXP_BITS = EXP_BITS_DEF,
  parameter int unsigned MOD_BITS = MOD_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  modulus_we_i,
  input  logic [MODULUS_W-1:0]  modulus_i,
  input  logic [BASE_W-1:0]     base_i,
  input  logic [EXPONENT_W-1:0] exponent_i,
  input  dp_cmd_t               cmd_i,
  output dp_status_t            status_o,
  output logic [POWER_W-1:0]    power_o
);

  logic [MOD_BITS-1:0] m_q;
  logic [BASE_W-1:0]   base_sr_q;
  logic [EXP_BITS-1:0] e_q;
  logic [MOD_BITS-1:0] acc_q;
  logic [MOD_BITS-1:0] b_q;
  logic [MOD_BITS-1:0] op_q;
  logic [MOD_BITS-1:0] r1_q;
  logic [MOD_BITS-1:0] r2_q;

  logic [MOD_BITS-1:0] add1;
  logic [MOD_BITS-1:0] add2;
  logic [MOD_BITS-1:0] r1_d;
  logic [MOD_BITS-1:0] r2_d;

  // Lane 1 forms acc*b, lane 2 forms b*b; both scan the bits of b from the top.
  // During base reduction lane 2 shifts in the base one bit at a time.
  always_comb begin
    add1 = op_q[MOD_BITS-1] ? acc_q : '0;
    if (cmd_i.reduce_step) begin
      add2 = {{(MOD_BITS-1){1'b0}}, base_sr_q[BASE_W-1]};
    end else begin
      add2 = op_q[MOD_BITS-1] ? b_q : '0;
    end
  end

  mexp_lane #(.W(MOD_BITS)) u_lane1 (
    .r_i   (r1_q),
    .add_i (add1),
    .m_i   (m_q),
    .r_o   (r1_d)
  );

  mexp_lane #(.W(MOD_BITS)) u_lane2 (
    .r_i   (r2_q),
    .add_i (add2),
    .m_i   (m_q),
    .r_o   (r2_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_q <= MOD_BITS'(MODULUS_RESET);
    end else if (modulus_we_i) begin
      m_q <= MOD_BITS'(modulus_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      base_sr_q <= base_i;
      e_q       <= EXP_BITS'(exponent_i);
      acc_q     <= status_o.m_small ? '0 : MOD_BITS'(1);
      r2_q      <= '0;
    end
    if (cmd_i.reduce_step) begin
      r2_q      <= r2_d;
      base_sr_q <= {base_sr_q[BASE_W-2:0], 1'b0};
    end
    if (cmd_i.mul_start) begin
      b_q  <= r2_q;
      op_q <= r2_q;
      r1_q <= '0;
      r2_q <= '0;
    end
    if (cmd_i.mul_step) begin
      r1_q <= r1_d;
      r2_q <= r2_d;
      op_q <= {op_q[MOD_BITS-2:0], 1'b0};
    end
    if (cmd_i.commit) begin
      if (e_q[0]) begin
        acc_q <= r1_q;
      end
      e_q <= e_q >> 1;
    end
  end

  assign status_o.m_small = (m_q < MOD_BITS'(2));
  assign status_o.e_zero  = (e_q == '0);
  assign power_o          = POWER_W'(acc_q);

endmodule
`default_nettype wire

[hdl/mexp_ctrl.sv]
`default_nettype none
module mexp_ctrl
  import mexp_pkg::*;
#(
  parameter int unsigned MOD_BITS = MOD_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o,
  output logic       busy_o,
  output logic       done_o
);

  localparam int unsigned CNT_MAX = (BASE_W > MOD_BITS) ? BASE_W : MOD_BITS;
  localparam int unsigned CNT_W = $clog2(CNT_MAX + 1);

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             cnt_last;

  assign cnt_last = (cnt_q == CNT_W'(1));

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = CNT_W'(BASE_W);
          state_d    = status_i.m_small ? S_FIN : S_REDUCE;
        end
      end
      S_REDUCE: begin
        cmd_o.reduce_step = 1'b1;
        cnt_d             = cnt_q - CNT_W'(1);
        if (cnt_last) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status_i.e_zero) begin
          state_d = S_FIN;
        end else begin
          cmd_o.mul_start = 1'b1;
          cnt_d           = CNT_W'(MOD_BITS);
          state_d         = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul_step = 1'b1;
        cnt_d          = cnt_q - CNT_W'(1);
        if (cnt_last) begin
          state_d = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = S_CHECK;
      end
      S_FIN: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_FIN);

endmodule
`default_nettype wire

[tb/sv/tb_modular_exponentiation.sv]
`timescale 1ns / 1ps

module tb_modular_exponentiation;
  import mexp_pkg::*;

  // The limit leaves room for each of the roughly 1850 requests at the worst
  // case plus the longest sender gap, several times over.
  localparam int unsigned CYCLE_LIMIT = 12_000_000;
  // Quiet cycles after the last result, a little more than the worst latency,
  // so that a stray extra result is still caught.
  localparam int unsigned TAIL_CYCLES = 1100;
  localparam logic [MODULUS_W-1:0] MODULUS_MAX = '1;
  localparam logic [BASE_W-1:0] BASE_MAX = '1;
  localparam logic [EXPONENT_W-1:0] EXPONENT_MAX = '1;

  // One outstanding request, together with the power that it must produce.
  typedef struct {
    logic [BASE_W-1:0]     base;
    logic [EXPONENT_W-1:0] exponent;
    logic [MODULUS_W-1:0]  modulus;
    logic [POWER_W-1:0]    power;
  } power_request_t;

  // Every input starts at a known value. Reset is held from time zero.
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [BASE_W-1:0] base_i = '0;
  logic [EXPONENT_W-1:0] exponent_i = '0;
  logic done_o;
  logic [POWER_W-1:0] power_o;
  logic modulus_we_i = 1'b0;
  logic [MODULUS_W-1:0] modulus_i = '0;

  // The testbench's own copy of the modulus register. It changes only while
  // the block is idle, so it is valid for every request in flight.
  logic [MODULUS_W-1:0] modulus_now = MODULUS_RESET[MODULUS_W-1:0];
  // Powers still owed by the block, oldest first.
  power_request_t pending_powers[$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  // When this is clear, the sender puts no gaps between requests.
  bit gaps_on = 1'b1;

  modular_exponentiation dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .base_i      (base_i),
    .exponent_i  (exponent_i),
    .done_o      (done_o),
    .power_o     (power_o),
    .modulus_we_i(modulus_we_i),
    .modulus_i   (modulus_i)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Watchdog. A hung block or a lost result ends here as a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Right-to-left square-and-multiply. The running product starts at 1, and
  // each set exponent bit folds the current square of the base into it.
  // Operands stay below the modulus, so every product fits in 64 bits.
  // A modulus below 2 lies outside the legal range. Everything modulo 1 is 0,
  // and a zero modulus is treated the same way.
  function automatic logic [POWER_W-1:0] mod_power(input logic [BASE_W-1:0] base,
                                                   input logic [EXPONENT_W-1:0] exponent,
                                                   input logic [MODULUS_W-1:0] modulus);
    longint unsigned m;
    longint unsigned square;
    longint unsigned product;
    int i;
    m = modulus;
    if (m < 2) return '0;
    square = base % m;
    product = 1;
    for (i = 0; i < EXPONENT_W; i++) begin
      if (exponent[i]) product = (product * square) % m;
      square = (square * square) % m;
    end
    return product[POWER_W-1:0];
  endfunction

  // Most gaps are short, some are medium and a few are long.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (!gaps_on) return 0;
    roll = $urandom_range(99);
    if (roll < 40) return 0;
    if (roll < 85) return $urandom_range(3, 1);
    if (roll < 97) return $urandom_range(20, 4);
    return $urandom_range(120, 21);
  endfunction

  // Random bases: mostly the full range, some tiny values, some values near
  // the modulus (so that the first reduction wraps or just fails to), and
  // the all-ones value.
  function automatic logic [BASE_W-1:0] pick_base();
    int unsigned roll;
    logic [BASE_W-1:0] value;
    roll = $urandom_range(99);
    value = BASE_W'($urandom);
    if (roll < 10) value = BASE_W'($urandom_range(3));
    else if (roll < 20) value = BASE_W'(modulus_now + $urandom_range(2) - 1);
    else if (roll < 25) value = BASE_MAX;
    return value;
  endfunction

  // Random exponents. The latency grows with the position of the top set
  // bit, so most exponents get a random length and only some use all 32 bits.
  function automatic logic [EXPONENT_W-1:0] pick_exponent();
    int unsigned roll;
    int unsigned bits;
    logic [EXPONENT_W-1:0] value;
    roll = $urandom_range(99);
    value = $urandom;
    if (roll < 4) begin
      value = '0;
    end else if (roll < 7) begin
      value = 1;
    end else if (roll < 10) begin
      value = EXPONENT_MAX;
    end else if (roll >= 25) begin
      bits = $urandom_range(EXPONENT_W, 1);
      if (bits < EXPONENT_W) value = value & ((32'd1 << bits) - 1);
      value[bits-1] = 1'b1;
    end
    return value;
  endfunction

  // Sends one request. The gap is counted either from the previous request
  // or from the moment the block went idle, so start is low at times during
  // the busy stretch and at times after it. Once a request has been taken,
  // start stays high. The block ignores it while busy, and the next call
  // either keeps it high or lowers it, so it is never lowered and raised in
  // the same time step.
  task automatic send_request(input logic [BASE_W-1:0] base,
                              input logic [EXPONENT_W-1:0] exponent);
    int unsigned gap;
    power_request_t entry;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      if ($urandom_range(1) == 1) begin
        do @(posedge clk_i); while (busy);
      end
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    base_i <= base;
    exponent_i <= exponent;
    // The request is taken at the first edge at which busy was low.
    do @(posedge clk_i); while (busy);
    entry.base = base;
    entry.exponent = exponent;
    entry.modulus = modulus_now;
    entry.power = mod_power(base, exponent, modulus_now);
    pending_powers.push_back(entry);
  endtask

  // Stops sending and waits until every owed power has come back and the
  // block reports idle. busy falls in the cycle after the last done strobe, so
  // the checker has already consumed that result when this returns.
  task automatic wait_for_results();
    start <= 1'b0;
    do @(posedge clk_i); while (pending_powers.size() != 0 || busy);
  endtask

  // Writes the modulus register, only ever while the block is idle.
  task automatic set_modulus(input logic [MODULUS_W-1:0] value);
    wait_for_results();
    modulus_we_i <= 1'b1;
    modulus_i <= value;
    @(posedge clk_i);
    modulus_we_i <= 1'b0;
    modulus_now = value;
    @(posedge clk_i);
  endtask

  // Compares each done strobe with the oldest owed power.
  initial begin : result_checker
    power_request_t owed;
    forever begin
      @(posedge clk_i);
      if (rst_ni && done_o) begin
        if (pending_powers.size() == 0) begin
          $display("%0t: power %0d arrived with no request outstanding",
                   $time, power_o);
          mismatches++;
        end else begin
          owed = pending_powers.pop_front();
          if (power_o !== owed.power) begin
            $display("%0t: power of %0d ** %0d mod %0d: expected %0d, actual %0d",
                     $time, owed.base, owed.exponent, owed.modulus, owed.power,
                     power_o);
            mismatches++;
          end
        end
      end
    end
  end

  // Corner cases under the reset modulus, 1000000007, without any write.
  // They cover a zero exponent (also with a zero base), a zero base, the
  // largest base and exponent, a base equal to the modulus, the top exponent
  // bit alone and alternating bit patterns.
  task automatic test_reset_modulus();
    send_request('0, '0);
    send_request(BASE_MAX, '0);
    send_request('0, 5);
    send_request(1, EXPONENT_MAX);
    send_request(BASE_MAX, EXPONENT_MAX);
    send_request(2, 1);
    send_request(2, 29);
    send_request(MODULUS_RESET[BASE_W-1:0], 3);
    send_request(MODULUS_RESET[BASE_W-1:0] - 30'd1, 2);
    send_request(3, 32'h8000_0000);
    send_request(30'h2AAA_AAAA, 32'hAAAA_AAAA);
    send_request(30'h1555_5555, 32'h5555_5555);
  endtask

  // The smallest and largest legal moduli, then 1 and 0, which lie outside
  // the legal range and must give a power of 0 even for a zero exponent.
  task automatic test_modulus_limits();
    set_modulus(2);
    send_request(BASE_MAX, 1);
    send_request(BASE_MAX - 30'd1, EXPONENT_MAX);
    send_request(3, '0);
    set_modulus(MODULUS_MAX);
    send_request(BASE_MAX, 7);
    send_request(BASE_MAX - 30'd1, EXPONENT_MAX);
    send_request(12345, 32'h0001_0001);
    set_modulus(1);
    send_request(BASE_MAX, 9);
    send_request(5, '0);
    set_modulus('0);
    send_request(7, 3);
    send_request(0, '0);
  endtask

  // One phase of random requests under a single modulus. Each phase decides
  // whether the sender idles at all, and now and then the sender holds off
  // until everything owed has come back.
  task automatic run_random_phase(input logic [MODULUS_W-1:0] modulus, input int count);
    int n;
    set_modulus(modulus);
    gaps_on = ($urandom_range(3) != 0);
    for (n = 0; n < count; n++) begin
      send_request(pick_base(), pick_exponent());
      if ($urandom_range(99) == 0) wait_for_results();
    end
    gaps_on = 1'b1;
  endtask

  // Random requests under a spread of moduli: the reset value, the extremes,
  // a power of two, a small prime, random odd and even values and small ones.
  task automatic test_random_moduli();
    logic [MODULUS_W-1:0] odd_value;
    logic [MODULUS_W-1:0] even_value;
    odd_value = MODULUS_W'($urandom_range(32'h3FFF_FFFF, 2) | 1);
    even_value = MODULUS_W'($urandom_range(32'h3FFF_FFFF, 2) & ~32'd1);
    run_random_phase(MODULUS_RESET[MODULUS_W-1:0], 180);
    run_random_phase(3, 180);
    run_random_phase(MODULUS_MAX, 180);
    run_random_phase(30'h2000_0000, 180);
    run_random_phase(65521, 180);
    run_random_phase(odd_value, 180);
    run_random_phase(even_value, 180);
    run_random_phase(MODULUS_W'($urandom_range(1000, 2)), 180);
    run_random_phase(MODULUS_W'($urandom_range(32'h3FFF_FFFF, 2)), 180);
    run_random_phase(2, 150);
  endtask

  // The sender waits for every result before each new request, so each one
  // starts on a fully idle block.
  task automatic test_drain_pauses();
    int n;
    set_modulus(MODULUS_W'($urandom_range(32'h3FFF_FFFF, 2)));
    for (n = 0; n < 30; n++) begin
      send_request(pick_base(), pick_exponent());
      wait_for_results();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_modulus();
    test_modulus_limits();
    test_random_moduli();
    test_drain_pauses();
    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
